// File: rtl/ses_pkg.sv
// Shared widths, limits and codes for the seismic event segmenter.
// No dependencies; imported by ses_div and seismic_event_segmenter.
package ses_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAG_BITS       = SAMPLE_BITS + 1;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUIET_BITS     = 16;
   localparam int NUMBER_BITS    = 16;
   localparam int OUT_INDEX_BITS = 24;
   localparam int ENERGY_BITS    = 48;
   localparam int RATIO_BITS     = 25;
   localparam int FRAC_BITS      = 8;
   localparam int RSP_DATA_BITS  = 144;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIT_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUIET_LIMIT   = 1'd1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_END   = 1'b1;

   localparam logic [CFG_BITS-1:0]    THRESHOLD_RESET = 16'd20;
   localparam logic [CFG_BITS-1:0]    QUIET_RESET     = 16'd200;
   localparam logic [NUMBER_BITS-1:0] NUMBER_RESET    = 16'd1;
   localparam logic [QUIET_BITS-1:0]  QUIET_MAX       = '1;
   localparam logic [ENERGY_BITS-1:0] ENERGY_MAX      = '1;
   localparam logic [RATIO_BITS-1:0]  RATIO_MAX       = '1;

endpackage

// File: rtl/ses_div.sv
// Restoring divider, one quotient bit per cycle: (energy << 8) / divisor,
// saturating to the ratio width. Depends on ses_pkg.
module ses_div
   import ses_pkg::*;
#(
   parameter int DIVISOR_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ENERGY_BITS-1:0]  energy,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic [RATIO_BITS-1:0]   quotient
);

   localparam int HI_BITS    = ENERGY_BITS - (RATIO_BITS - FRAC_BITS);
   localparam int CMP_BITS   = (DIVISOR_BITS > HI_BITS) ? DIVISOR_BITS : HI_BITS;
   localparam int COUNT_BITS = $clog2(RATIO_BITS);

   logic                    busy_ff;
   logic                    done_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [RATIO_BITS-1:0]   shift_ff;

   logic [HI_BITS-1:0]      energy_hi;
   logic                    overflow;
   logic [DIVISOR_BITS:0]   trial;
   logic                    fits;
   logic [DIVISOR_BITS-1:0] rem_in;

   // high dividend part at or above divisor means quotient >= 2^RATIO_BITS
   assign energy_hi = energy[ENERGY_BITS-1:RATIO_BITS-FRAC_BITS];
   assign overflow  = CMP_BITS'(energy_hi) >= CMP_BITS'(divisor);

   assign trial  = {rem_ff, shift_ff[RATIO_BITS-1]};
   assign fits   = trial >= {1'b0, divisor};
   assign rem_in = fits ? DIVISOR_BITS'(trial - {1'b0, divisor})
                        : trial[DIVISOR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (start && overflow) || (!start && busy_ff && count_ff == '0);
         if (start) begin
            if (overflow) begin
               shift_ff <= RATIO_MAX;
            end else begin
               rem_ff   <= DIVISOR_BITS'(energy_hi);
               shift_ff <= {energy[RATIO_BITS-FRAC_BITS-1:0], FRAC_BITS'(0)};
               count_ff <= COUNT_BITS'(RATIO_BITS - 1);
               busy_ff  <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= {shift_ff[RATIO_BITS-2:0], fits};
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// File: rtl/seismic_event_segmenter.sv
// Seismic event segmenter top level: threshold detection, quiet hold-off,
// energy accumulation and result buffering. Depends on ses_pkg and ses_div.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------------
//  req_     | in        | req_tvalid/tready   | tdata[15:0] sample (signed)
//  rsp_     | out       | rsp_tvalid/tready   | tuser event_kind; tdata number/index/
//           |           |                     | length/energy/ratio
//  csr_     | in        | csr_wen             | csr_index, csr_wdata[15:0]
//
// Sequencing: a request is taken in IDLE and evaluated in the next cycle. An
// end result runs the divider, one quotient bit per cycle, or the divider
// saturates at once when the ratio overflows. No new request is taken until
// the sequencer is back in IDLE.
// Reset: synchronous, active high; no clearing pass.
// Stalls: a waiting result in the output register does not block the next
// request; the sequencer holds in EMIT only when a second result is ready.
module seismic_event_segmenter
   import ses_pkg::*;
#(
   parameter int INDEX_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   // requests
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [SAMPLE_BITS-1:0]    req_tdata,   // [15:0] sample
   // results
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [15:0] event_number, [39:16] sample_index,
                                                  // [63:40] event_length,
                                                  // [111:64] event_energy,
                                                  // [136:112] energy_ratio, rest zero
   output logic                      rsp_tuser,   // [0] event_kind
   // configuration
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [CFG_BITS-1:0] threshold_ff;
   logic [CFG_BITS-1:0] quiet_limit_ff;

   // detector state
   logic [INDEX_BITS-1:0]  index_ff;
   logic                   active_ff;
   logic [INDEX_BITS-1:0]  start_ff;
   logic [QUIET_BITS-1:0]  quiet_ff;
   logic [ENERGY_BITS-1:0] energy_ff;
   logic [NUMBER_BITS-1:0] number_ff;

   // request and pending result
   logic [SAMPLE_BITS-1:0]    sample_ff;
   logic                      pend_kind_ff;
   logic [NUMBER_BITS-1:0]    pend_number_ff;
   logic [OUT_INDEX_BITS-1:0] pend_index_ff;
   logic [OUT_INDEX_BITS-1:0] pend_length_ff;
   logic [ENERGY_BITS-1:0]    pend_energy_ff;
   logic [INDEX_BITS-1:0]     divisor_ff;
   logic                      div_start_ff;

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff;
   logic [NUMBER_BITS-1:0]    rsp_number_ff;
   logic [OUT_INDEX_BITS-1:0] rsp_index_ff;
   logic [OUT_INDEX_BITS-1:0] rsp_length_ff;
   logic [ENERGY_BITS-1:0]    rsp_energy_ff;
   logic [RATIO_BITS-1:0]     rsp_ratio_ff;

   // evaluation logic
   logic [MAG_BITS-1:0]    mag;
   logic                   hit;
   logic [ENERGY_BITS:0]   energy_sum;
   logic [ENERGY_BITS-1:0] energy_in;
   logic [QUIET_BITS-1:0]  quiet_in;
   logic [CFG_BITS-1:0]    limit;
   logic                   opens;
   logic                   closes;
   logic [INDEX_BITS-1:0]  length_in;
   logic                   out_free;

   logic                   div_busy;
   logic                   div_done;
   logic [RATIO_BITS-1:0]  div_quotient;

   // magnitude in one extra bit so the most negative sample stays exact
   assign mag = sample_ff[SAMPLE_BITS-1]
              ? MAG_BITS'(MAG_BITS'(0) - {1'b1, sample_ff})
              : {1'b0, sample_ff};
   assign hit = mag >= {1'b0, threshold_ff};

   // saturating add of twice the magnitude
   assign energy_sum = {1'b0, energy_ff} + (ENERGY_BITS + 1)'({mag, 1'b0});
   assign energy_in  = energy_sum[ENERGY_BITS] ? ENERGY_MAX : energy_sum[ENERGY_BITS-1:0];

   assign quiet_in = hit ? '0 : ((quiet_ff == QUIET_MAX) ? quiet_ff : quiet_ff + 1'b1);
   // a zero quiet limit behaves as one
   assign limit    = (quiet_limit_ff == '0) ? CFG_BITS'(1) : quiet_limit_ff;

   assign opens     = hit && !active_ff;
   // a hit clears the quiet count, so only a quiet sample can close an event
   assign closes    = active_ff && !hit && (quiet_in >= limit);
   assign length_in = index_ff - start_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   ses_div #(
      .DIVISOR_BITS(INDEX_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .energy   (pend_energy_ff),
      .divisor  (divisor_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         quiet_limit_ff <= QUIET_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_HIT_THRESHOLD: threshold_ff   <= csr_wdata;
            CSR_QUIET_LIMIT:   quiet_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer, detector state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         quiet_ff     <= '0;
         energy_ff    <= '0;
         number_ff    <= NUMBER_RESET;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // kick the divider in the cycle after an event closes
         div_start_ff <= (state_ff == ST_EVAL) && closes;
         // drop a result once taken; EMIT handles its own reload
         if (rsp_valid_ff && rsp_tready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  sample_ff <= req_tdata;
                  state_ff  <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               quiet_ff       <= quiet_in;
               pend_number_ff <= number_ff;
               pend_index_ff  <= OUT_INDEX_BITS'(index_ff);
               if (index_ff != INDEX_MAX) begin
                  index_ff <= index_ff + 1'b1;
               end
               if (opens) begin
                  // open an event: start result carries zeros for the totals
                  active_ff      <= 1'b1;
                  start_ff       <= index_ff;
                  energy_ff      <= energy_in;
                  pend_kind_ff   <= KIND_START;
                  pend_length_ff <= '0;
                  pend_energy_ff <= '0;
                  state_ff       <= ST_EMIT;
               end else if (closes) begin
                  // close the event and hand energy and length to the divider
                  active_ff      <= 1'b0;
                  energy_ff      <= '0;
                  number_ff      <= number_ff + 1'b1;
                  pend_kind_ff   <= KIND_END;
                  pend_length_ff <= OUT_INDEX_BITS'(length_in);
                  pend_energy_ff <= energy_ff;
                  divisor_ff     <= length_in;
                  state_ff       <= ST_DIV;
               end else begin
                  if (hit) begin
                     energy_ff <= energy_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= pend_kind_ff;
                  rsp_number_ff <= pend_number_ff;
                  rsp_index_ff  <= pend_index_ff;
                  rsp_length_ff <= pend_length_ff;
                  rsp_energy_ff <= pend_energy_ff;
                  rsp_ratio_ff  <= (pend_kind_ff == KIND_END) ? div_quotient : '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_ratio_ff, rsp_energy_ff, rsp_length_ff,
                                       rsp_index_ff, rsp_number_ff});

   // the divider only runs while the sequencer waits for it
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      (div_busy || div_done) |-> state_ff == ST_DIV)
      else $error("divider active outside the divide state");

   // a free output register is always loaded when EMIT is left
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> rsp_valid_ff)
      else $error("result lost on leaving EMIT");

   // an event closes only together with an end result
   a_close_kind: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> (pend_kind_ff == KIND_END && state_ff == ST_DIV))
      else $error("event closed without end result");

   // no request is taken while the divider is busy
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("request taken during division");

endmodule
